@@ rtl/kdc_pkg.sv @@
// Package for the key action edge and double-click detector.
// Holds the word types, per-slot state entry, configuration record and codes.
// Has no dependencies.
package kdc_pkg;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [TIME_BITS-1:0] WINDOW_RESET = TIME_BITS'(500);

  typedef enum logic [1:0] {
    MODE_PRESS   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_DOUBLE  = 2'd2,
    MODE_HOLD    = 2'd3
  } kdc_mode_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ARMED = 2'd1,
    PH_USED  = 2'd2
  } kdc_phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE = 3'd0,
    REG_MODES  = 3'd1,
    REG_BOUND  = 3'd2,
    REG_WINDOW = 3'd3
  } kdc_reg_e;

  typedef struct packed {
    logic [SLOT_W-1:0]    slot;
    logic                 key_down;
    logic [TIME_BITS-1:0] now;
  } kdc_in_t;

  typedef struct packed {
    logic              fire;
    logic [SLOT_W-1:0] slot_out;
  } kdc_out_t;

  typedef struct packed {
    logic                 pressed;
    kdc_phase_e           phase;
    logic [TIME_BITS-1:0] rtime;
  } kdc_entry_t;

  localparam int unsigned ENTRY_W = $bits(kdc_entry_t);

  typedef struct packed {
    logic                   enable;
    logic [2*SLOTS-1:0]     modes;
    logic [SLOTS-1:0]       bound;
    logic [TIME_BITS-1:0]   window;
  } kdc_cfg_t;

  typedef struct packed {
    logic we;
    logic fire;
  } kdc_upd_t;

endpackage

@@ rtl/kdc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Standalone; has no package dependency.
module kdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/kdc_update.sv @@
// Per-slot edge and double-click decision for one sampled word.
// Depends on kdc_pkg for the entry, configuration and word types.
module kdc_update (
  input  kdc_pkg::kdc_cfg_t   cfg_i,
  input  kdc_pkg::kdc_in_t    item_i,
  input  kdc_pkg::kdc_entry_t entry_i,
  output kdc_pkg::kdc_entry_t entry_o,
  output kdc_pkg::kdc_upd_t   upd_o
);
  import kdc_pkg::*;

  kdc_mode_e            mode;
  logic [TIME_BITS-1:0] diff;

  assign mode = kdc_mode_e'(cfg_i.modes[{item_i.slot, 1'b0} +: 2]);
  assign diff = item_i.now - entry_i.rtime;

  always_comb begin
    entry_o    = entry_i;
    upd_o.we   = 1'b0;
    upd_o.fire = 1'b0;
    if (cfg_i.enable && cfg_i.bound[item_i.slot]) begin
      unique case (mode)
        MODE_HOLD: begin
          upd_o.fire = item_i.key_down;
        end
        MODE_PRESS, MODE_RELEASE, MODE_DOUBLE: begin
          upd_o.we = 1'b1;
          if (item_i.key_down) begin
            if (mode == MODE_PRESS && !entry_i.pressed) begin
              upd_o.fire = 1'b1;
            end
            if (mode == MODE_DOUBLE && entry_i.phase == PH_ARMED) begin
              if (diff < cfg_i.window) begin
                upd_o.fire    = 1'b1;
                entry_o.phase = PH_USED;
              end else begin
                entry_o.phase = PH_IDLE;
              end
            end
            entry_o.pressed = 1'b1;
          end else if (entry_i.pressed) begin
            if (mode == MODE_RELEASE) begin
              upd_o.fire = 1'b1;
            end
            if (mode == MODE_DOUBLE) begin
              if (entry_i.phase == PH_IDLE) begin
                entry_o.phase = PH_ARMED;
                entry_o.rtime = item_i.now;
              end else if (entry_i.phase != PH_ARMED) begin
                entry_o.phase = PH_IDLE;
              end
            end
            entry_o.pressed = 1'b0;
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/key_action_edge_doubleclick_detector.sv @@
// Key action edge and double-click detector, top level.
// Words are registered in stage 1, then at the output; one word per cycle
// unless the output stalls, set by the single read and write port of the
// slot state RAM; same-slot words back to back use forwarding. Reset loads
// the default configuration and clears pipeline valids and per-slot valid
// bits, so every slot reads as released and idle until first written.
module key_action_edge_doubleclick_detector (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  kdc_pkg::kdc_in_t                   in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output kdc_pkg::kdc_out_t                  out_word_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [kdc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [kdc_pkg::CFG_W-1:0]          cfg_data_i
);
  import kdc_pkg::*;

  kdc_cfg_t             cfg_q, cfg_d;
  logic                 s1_vld_q, s1_vld_d;
  kdc_in_t              s1_item_q;
  logic                 fwd_hit_q;
  kdc_entry_t           fwd_q;
  logic [SLOTS-1:0]     valid_q, valid_d;
  logic                 out_vld_q, out_vld_d;
  kdc_out_t             out_q;

  logic                 accept;
  logic                 out_free;
  logic                 s1_adv;
  logic                 wr_en;
  logic [ENTRY_W-1:0]   ram_rdata;
  kdc_entry_t           entry_cur;
  kdc_entry_t           entry_nxt;
  kdc_upd_t             upd;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (kdc_reg_e'(cfg_index_i))
        REG_ENABLE: cfg_d.enable = cfg_data_i[0];
        REG_MODES:  cfg_d.modes  = cfg_data_i[2*SLOTS-1:0];
        REG_BOUND:  cfg_d.bound  = cfg_data_i[SLOTS-1:0];
        REG_WINDOW: cfg_d.window = cfg_data_i[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = s1_vld_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_adv     = s1_vld_q && out_free;
  assign wr_en      = s1_adv && upd.we;

  kdc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_item_q.slot),
    .wdata_i (entry_nxt),
    .re_i    (accept),
    .raddr_i (in_word_i.slot),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (fwd_hit_q) begin
      entry_cur = fwd_q;
    end else if (valid_q[s1_item_q.slot]) begin
      entry_cur = kdc_entry_t'(ram_rdata);
    end else begin
      entry_cur = '0;
    end
  end

  kdc_update u_update (
    .cfg_i   (cfg_q),
    .item_i  (s1_item_q),
    .entry_i (entry_cur),
    .entry_o (entry_nxt),
    .upd_o   (upd)
  );

  always_comb begin
    valid_d = valid_q;
    if (wr_en) begin
      valid_d[s1_item_q.slot] = 1'b1;
    end
    s1_vld_d = s1_vld_q;
    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (out_free) begin
      out_vld_d = s1_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable <= 1'b1;
      cfg_q.modes  <= '0;
      cfg_q.bound  <= '0;
      cfg_q.window <= WINDOW_RESET;
      valid_q      <= '0;
      s1_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      fwd_hit_q    <= 1'b0;
    end else begin
      cfg_q     <= cfg_d;
      valid_q   <= valid_d;
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
      if (accept) begin
        fwd_hit_q <= wr_en && (s1_item_q.slot == in_word_i.slot);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_word_i;
      fwd_q     <= entry_nxt;
    end
    if (s1_adv) begin
      out_q.fire     <= upd.fire;
      out_q.slot_out <= s1_item_q.slot;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

@@ rtl/kdc_checker.sv @@
// Port-level checker for the key action edge and double-click detector.
// Depends on kdc_pkg; bound to the top level at the end of this file.
module kdc_props (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_i,
  input kdc_pkg::kdc_in_t              in_word_i,
  input logic                          out_valid_i,
  input logic                          out_stall_i,
  input kdc_pkg::kdc_out_t             out_word_i
);

  // The input side only stalls when a result is held back downstream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i |-> (out_valid_i && out_stall_i))
    else $error("input stalled without a blocked result");

  // A result appearing on an empty output comes from an accepted word that passed the stage-1 and output registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && !in_stall_i, 2))
    else $error("result appeared without an accepted word");

  // A stalled result stays and keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=> (out_valid_i && $stable(out_word_i)))
    else $error("stalled result changed");

  // The slot echo of a new result matches the slot of the word accepted into stage 1 ahead of it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> (out_word_i.slot_out == $past(in_word_i.slot, 2)))
    else $error("slot echo does not match accepted word");

endmodule

bind key_action_edge_doubleclick_detector kdc_props u_kdc_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_i  (out_word_o)
);
